// ===== sv/sqch_pkg.sv =====
// Shared types, constants and helpers for the square channel with sweep.
// Used by sqch_in_reg, sqch_core and square_channel_with_sweep.
`default_nettype none

package sqch_pkg;

	// channel configuration constants
	localparam int LENGTH_BASE  = 64;
	localparam int LENGTH_BITS  = 6;
	localparam int PERIOD_SCALE = 4;

	// derived widths
	localparam int LEN_W   = $clog2(LENGTH_BASE + 1);
	localparam int PLEN_W  = $clog2(2048 * PERIOD_SCALE + 1);
	localparam int PLEFT_W = (PLEN_W + 1 > 15) ? PLEN_W + 1 : 15;
	localparam int TMR_W   = PLEFT_W + 2;

	localparam logic [7:0] LEN_MASK = 8'((1 << LENGTH_BITS) - 1);

	// period_left saturates to the signed 15-bit range
	localparam logic signed [TMR_W-1:0] PLEFT_MIN = TMR_W'(-16384);
	localparam logic signed [TMR_W-1:0] PLEFT_MAX = TMR_W'(16383);

	localparam logic [10:0] FREQ_MAX = 11'h7FF;
	localparam logic [3:0]  VOL_MAX  = 4'hF;

	typedef enum logic [2:0] {
		CMD_WRITE  = 3'd0,
		CMD_TIMER  = 3'd1,
		CMD_LENGTH = 3'd2,
		CMD_ENV    = 3'd3,
		CMD_SWEEP  = 3'd4
	} cmd_t;

	typedef enum logic [2:0] {
		REG_SWEEP = 3'd0,
		REG_DUTY  = 3'd1,
		REG_ENV   = 3'd2,
		REG_FLO   = 3'd3,
		REG_CTRL  = 3'd4
	} reg_sel_t;

	localparam int NUM_REGS = 5;

	// duty waveforms, one bit per step
	localparam logic [7:0] DUTY_TABLE [4] = '{8'b0000_0001, 8'b1000_0001,
		8'b1000_0111, 8'b0111_1110};

	typedef struct packed {
		logic [2:0]  command;
		logic [2:0]  reg_select;
		logic [7:0]  write_data;
		logic [9:0]  clock_count;
	} item_t;

	typedef struct packed {
		logic [3:0] sample;
		logic       channel_on;
		logic       dac_on;
	} result_t;

	typedef struct packed {
		logic fire;
		logic valid;
	} stage_ctl_t;

	// period reload: (2048 - freq) * PERIOD_SCALE
	function automatic logic [PLEN_W-1:0] period_of(input logic [10:0] freq);
		logic [PLEN_W+3:0] t;
		t = (PLEN_W + 4)'(12'd2048 - {1'b0, freq}) * (PLEN_W + 4)'(PERIOD_SCALE);
		return t[PLEN_W-1:0];
	endfunction

endpackage

`default_nettype wire

// ===== sv/sqch_in_reg.sv =====
// Input register for the square channel: holds one accepted item.
// Depends on sqch_pkg.
`default_nettype none

module sqch_in_reg (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire sqch_pkg::item_t    item_in,
	input  wire logic               advance,
	output sqch_pkg::stage_ctl_t    ctl,
	output sqch_pkg::item_t         item_s1
);
	import sqch_pkg::*;

	logic valid_s1;

	assign ctl.valid = valid_s1;
	assign ctl.fire  = valid_s1 & advance;
	assign in_ready  = ~valid_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= item_in;
		end
	end

endmodule

`default_nettype wire

// ===== sv/sqch_core.sv =====
// Channel state and its combinational update for one item; produces the result
// from the updated state. Depends on sqch_pkg.
`default_nettype none

module sqch_core (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             fire,
	input  wire sqch_pkg::item_t  item,
	output sqch_pkg::result_t     res
);
	import sqch_pkg::*;

	logic [7:0]                regs_q [NUM_REGS];
	logic [7:0]                regs_d [NUM_REGS];
	logic [LEN_W-1:0]          len_q, len_d;
	logic                      len_en_q, len_en_d;
	logic [2:0]                env_pace_q, env_pace_d;
	logic [2:0]                env_cnt_q, env_cnt_d;
	logic                      env_up_q, env_up_d;
	logic [3:0]                vol_q, vol_d;
	logic [1:0]                duty_q, duty_d;
	logic [2:0]                step_q, step_d;
	logic [PLEN_W-1:0]         plen_q, plen_d;
	logic signed [PLEFT_W-1:0] pleft_q, pleft_d;
	logic [2:0]                sw_pace_q, sw_pace_d;
	logic [2:0]                sw_cnt_q, sw_cnt_d;
	logic                      en_q, en_d;
	logic                      dac_q, dac_d;

	// trigger values
	logic signed [9:0]  trig_len_raw;
	logic [LEN_W-1:0]   trig_len;
	logic [PLEN_W-1:0]  trig_period;
	logic               trig_dac;

	// timer
	logic signed [TMR_W-1:0] tmr_diff, tmr_sum, tmr_sat;
	logic                    tmr_wrap;

	// envelope
	logic [2:0] env_next;

	// sweep
	logic [10:0]       sw_freq, sw_delta, sw_dec, sw_new;
	logic [11:0]       sw_inc;
	logic              sw_over;
	logic [PLEN_W-1:0] sw_period;

	assign trig_len_raw = 10'(LENGTH_BASE) - 10'(regs_q[REG_DUTY] & LEN_MASK);
	assign trig_len     = trig_len_raw[9] ? '0 : LEN_W'(trig_len_raw);
	assign trig_period  = period_of({item.write_data[2:0], regs_q[REG_FLO]});
	assign trig_dac     = regs_q[REG_ENV][7:3] != 5'd0;

	assign tmr_diff = {{(TMR_W - PLEFT_W){pleft_q[PLEFT_W-1]}}, pleft_q}
		- TMR_W'(item.clock_count);
	assign tmr_wrap = tmr_diff[TMR_W-1] || (tmr_diff == '0);
	assign tmr_sum  = tmr_wrap ? tmr_diff + TMR_W'(plen_q) : tmr_diff;
	always_comb begin
		if (tmr_sum < PLEFT_MIN) begin
			tmr_sat = PLEFT_MIN;
		end else if (tmr_sum > PLEFT_MAX) begin
			tmr_sat = PLEFT_MAX;
		end else begin
			tmr_sat = tmr_sum;
		end
	end

	assign env_next = env_cnt_q + 3'd1;

	assign sw_freq   = {regs_q[REG_CTRL][2:0], regs_q[REG_FLO]};
	assign sw_delta  = sw_freq >> regs_q[REG_SWEEP][2:0];
	assign sw_inc    = {1'b0, sw_freq} + {1'b0, sw_delta};
	assign sw_dec    = sw_freq - sw_delta;
	assign sw_over   = ~regs_q[REG_SWEEP][3] && (sw_inc > {1'b0, FREQ_MAX});
	assign sw_new    = regs_q[REG_SWEEP][3] ? sw_dec : sw_inc[10:0];
	assign sw_period = period_of(sw_new);

	always_comb begin
		for (int i = 0; i < NUM_REGS; i++) begin
			regs_d[i] = regs_q[i];
		end
		len_d      = len_q;
		len_en_d   = len_en_q;
		env_pace_d = env_pace_q;
		env_cnt_d  = env_cnt_q;
		env_up_d   = env_up_q;
		vol_d      = vol_q;
		duty_d     = duty_q;
		step_d     = step_q;
		plen_d     = plen_q;
		pleft_d    = pleft_q;
		sw_pace_d  = sw_pace_q;
		sw_cnt_d   = sw_cnt_q;
		en_d       = en_q;
		dac_d      = dac_q;

		case (item.command)
			CMD_WRITE: begin
				case (item.reg_select)
					REG_SWEEP: regs_d[REG_SWEEP] = item.write_data;
					REG_DUTY:  regs_d[REG_DUTY]  = item.write_data;
					REG_ENV:   regs_d[REG_ENV]   = item.write_data;
					REG_FLO:   regs_d[REG_FLO]   = item.write_data;
					REG_CTRL: begin
						regs_d[REG_CTRL] = item.write_data;
						len_en_d = item.write_data[6];
						if (item.write_data[7]) begin
							len_d      = trig_len;
							env_pace_d = regs_q[REG_ENV][2:0];
							env_up_d   = regs_q[REG_ENV][3];
							vol_d      = regs_q[REG_ENV][7:4];
							env_cnt_d  = 3'd0;
							dac_d      = trig_dac;
							en_d       = trig_dac;
							duty_d     = regs_q[REG_DUTY][7:6];
							step_d     = 3'd0;
							plen_d     = trig_period;
							pleft_d    = PLEFT_W'(trig_period);
							sw_pace_d  = regs_q[REG_SWEEP][6:4];
							sw_cnt_d   = regs_q[REG_SWEEP][6:4];
						end
					end
					default: ;
				endcase
			end
			CMD_TIMER: begin
				pleft_d = PLEFT_W'(tmr_sat);
				if (tmr_wrap) begin
					step_d = step_q + 3'd1;
				end
			end
			CMD_LENGTH: begin
				if (len_en_q) begin
					if (len_q != '0) begin
						len_d = len_q - LEN_W'(1);
					end
					if (len_q <= LEN_W'(1)) begin
						en_d = 1'b0;
					end
				end
			end
			CMD_ENV: begin
				if (env_pace_q != 3'd0) begin
					env_cnt_d = env_next;
					if (env_next >= env_pace_q) begin
						env_cnt_d = 3'd0;
						if (env_up_q) begin
							if (vol_q != VOL_MAX) begin
								vol_d = vol_q + 4'd1;
							end
						end else if (vol_q != 4'd0) begin
							vol_d = vol_q - 4'd1;
						end
					end
				end
			end
			CMD_SWEEP: begin
				if (sw_pace_q == 3'd0) begin
					sw_pace_d = regs_q[REG_SWEEP][6:4];
					sw_cnt_d  = regs_q[REG_SWEEP][6:4];
				end else if (sw_cnt_q > 3'd1) begin
					sw_cnt_d = sw_cnt_q - 3'd1;
				end else begin
					sw_cnt_d = sw_pace_q;
					if (sw_over) begin
						en_d = 1'b0;
					end else if (regs_q[REG_SWEEP][2:0] != 3'd0) begin
						regs_d[REG_FLO]       = sw_new[7:0];
						regs_d[REG_CTRL][2:0] = sw_new[10:8];
						plen_d                = sw_period;
						pleft_d               = PLEFT_W'(sw_period);
					end
				end
			end
			default: ;
		endcase
	end

	assign res.sample     = DUTY_TABLE[duty_d][step_d] ? vol_d : 4'd0;
	assign res.channel_on = en_d;
	assign res.dac_on     = dac_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				regs_q[i] <= 8'd0;
			end
			len_q      <= '0;
			len_en_q   <= 1'b0;
			env_pace_q <= 3'd0;
			env_cnt_q  <= 3'd0;
			env_up_q   <= 1'b0;
			vol_q      <= 4'd0;
			duty_q     <= 2'd0;
			step_q     <= 3'd0;
			plen_q     <= '0;
			pleft_q    <= '0;
			sw_pace_q  <= 3'd0;
			sw_cnt_q   <= 3'd0;
			en_q       <= 1'b0;
			dac_q      <= 1'b0;
		end else if (fire) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				regs_q[i] <= regs_d[i];
			end
			len_q      <= len_d;
			len_en_q   <= len_en_d;
			env_pace_q <= env_pace_d;
			env_cnt_q  <= env_cnt_d;
			env_up_q   <= env_up_d;
			vol_q      <= vol_d;
			duty_q     <= duty_d;
			step_q     <= step_d;
			plen_q     <= plen_d;
			pleft_q    <= pleft_d;
			sw_pace_q  <= sw_pace_d;
			sw_cnt_q   <= sw_cnt_d;
			en_q       <= en_d;
			dac_q      <= dac_d;
		end
	end

endmodule

`default_nettype wire

// ===== sv/square_channel_with_sweep.sv =====
// Top level of the square sound channel with frequency sweep.
// Instantiates sqch_in_reg and sqch_core; uses sqch_pkg.
//
//   channel  signals                                        direction
//   input    in_valid/in_ready, command, reg_select,        in
//            write_data, clock_count
//   output   out_valid/out_ready, sample, channel_on, dac_on out
//
// An item is registered on accept; the channel state is updated and the result
// registered as it leaves the input register. One item per cycle is sustained
// while the output is not stalled; the input register advances whenever the
// result register is free or being drained. A stalled output holds one result
// and one waiting item. Reset clears the channel state and both valid flags.
`default_nettype none

module square_channel_with_sweep (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [2:0] command,
	input  wire logic [2:0] reg_select,
	input  wire logic [7:0] write_data,
	input  wire logic [9:0] clock_count,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [3:0]      sample,
	output logic            channel_on,
	output logic            dac_on
);
	import sqch_pkg::*;

	item_t      item_in, item_s1;
	stage_ctl_t ctl;
	result_t    res, res_q;
	logic       out_valid_q;
	logic       advance;

	assign item_in = '{command: command, reg_select: reg_select,
		write_data: write_data, clock_count: clock_count};

	assign advance = ~out_valid_q | out_ready;

	sqch_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.item_in  (item_in),
		.advance  (advance),
		.ctl      (ctl),
		.item_s1  (item_s1)
	);

	sqch_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (ctl.fire),
		.item   (item_s1),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= ctl.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.fire) begin
			res_q <= res;
		end
	end

	assign out_valid  = out_valid_q;
	assign sample     = res_q.sample;
	assign channel_on = res_q.channel_on;
	assign dac_on     = res_q.dac_on;

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking bench for square_channel_with_sweep: directed and random commands,
// every item checked against a channel model kept in step with accepted items.
// Depends on sqch_pkg and the square_channel_with_sweep RTL.
`default_nettype none

module tb_top;
	import sqch_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 10;
	localparam int MAX_PRINTS = 40;
	localparam logic [7:0] TRIGGER = 8'h80;
	localparam logic [7:0] DUTY_WAVES [4] = '{8'h01, 8'h81, 8'h87, 8'h7E};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [2:0] command = '0;
	logic [2:0] reg_select = '0;
	logic [7:0] write_data = '0;
	logic [9:0] clock_count = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [3:0] sample;
	logic channel_on;
	logic dac_on;

	// channel model state
	logic [7:0] chan_regs [NUM_REGS] = '{default: '0};
	int length_left = 0;
	logic length_enable = 1'b0;
	logic [2:0] env_pace = '0;
	int env_count = 0;
	logic env_up = 1'b0;
	logic [3:0] volume = '0;
	logic [1:0] duty_mode = '0;
	logic [2:0] duty_step = '0;
	int period_len = 0;
	int period_left = 0;
	logic [2:0] sweep_pace = '0;
	logic [2:0] sweep_count = '0;
	logic chan_on = 1'b0;
	logic dac_enabled = 1'b0;

	result_t expected_samples [$];
	int fail_count = 0;
	int idle_cycles = 0;
	bit idling_enabled = 1'b1;

	square_channel_with_sweep dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(command),
		.reg_select(reg_select),
		.write_data(write_data),
		.clock_count(clock_count),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sample(sample),
		.channel_on(channel_on),
		.dac_on(dac_on)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic [10:0] channel_freq();
		return {chan_regs[REG_CTRL][2:0], chan_regs[REG_FLO]};
	endfunction

	function automatic void reload_period();
		period_len = (2048 - int'(channel_freq())) * PERIOD_SCALE;
		period_left = period_len;
	endfunction

	function automatic result_t step_channel(input logic [2:0] cmd, input logic [2:0] sel,
			input logic [7:0] data, input logic [9:0] clocks);
		int len;
		int f;
		int nf;
		int shift;
		bit ovf;
		result_t res;
		case (cmd)
			CMD_WRITE: begin
				if (sel < NUM_REGS) begin
					chan_regs[sel] = data;
					if (sel == REG_CTRL) begin
						length_enable = data[6];
						if (data[7]) begin
							len = LENGTH_BASE - int'(chan_regs[REG_DUTY] & LEN_MASK);
							length_left = (len < 0) ? 0 : len;
							env_pace = chan_regs[REG_ENV][2:0];
							env_up = chan_regs[REG_ENV][3];
							volume = chan_regs[REG_ENV][7:4];
							env_count = 0;
							dac_enabled = |chan_regs[REG_ENV][7:3];
							chan_on = dac_enabled;
							duty_mode = chan_regs[REG_DUTY][7:6];
							duty_step = '0;
							reload_period();
							sweep_pace = chan_regs[REG_SWEEP][6:4];
							sweep_count = sweep_pace;
						end
					end
				end
			end
			CMD_TIMER: begin
				period_left -= int'(clocks);
				if (period_left <= 0) begin
					period_left += period_len;
					duty_step = duty_step + 3'd1;
				end
				if (period_left < -16384)
					period_left = -16384;
				if (period_left > 16383)
					period_left = 16383;
			end
			CMD_LENGTH: begin
				if (length_enable) begin
					if (length_left > 0)
						length_left--;
					if (length_left == 0)
						chan_on = 1'b0;
				end
			end
			CMD_ENV: begin
				if (env_pace != 0) begin
					env_count++;
					if (env_count >= env_pace) begin
						env_count = 0;
						if (env_up) begin
							if (volume != VOL_MAX)
								volume++;
						end else if (volume != 0) begin
							volume--;
						end
					end
				end
			end
			CMD_SWEEP: begin
				if (sweep_pace == 0) begin
					sweep_pace = chan_regs[REG_SWEEP][6:4];
					sweep_count = sweep_pace;
				end else if (sweep_count > 1) begin
					sweep_count--;
				end else begin
					sweep_count = sweep_pace;
					shift = int'(chan_regs[REG_SWEEP][2:0]);
					f = int'(channel_freq());
					ovf = 1'b0;
					if (!chan_regs[REG_SWEEP][3]) begin
						nf = f + (f >> shift);
						if (nf > int'(FREQ_MAX)) begin
							chan_on = 1'b0;
							ovf = 1'b1;
						end
					end else begin
						nf = f - (f >> shift);
					end
					// zero shift leaves the frequency alone
					if (shift != 0 && !ovf) begin
						chan_regs[REG_FLO] = nf[7:0];
						chan_regs[REG_CTRL][2:0] = nf[10:8];
						reload_period();
					end
				end
			end
			default: ;
		endcase
		res.sample = DUTY_WAVES[duty_mode][duty_step] ? volume : 4'd0;
		res.channel_on = chan_on;
		res.dac_on = dac_enabled;
		return res;
	endfunction

	task automatic report_fail(input string msg);
		fail_count++;
		if (fail_count <= MAX_PRINTS)
			$display("ERROR at %0t: %s", $time, msg);
	endtask

	function automatic logic [9:0] pick_clocks();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return 10'($urandom_range(0, 31));
		else if (r < 80)
			return 10'($urandom_range(0, 1023));
		else
			return $urandom_range(0, 1) ? 10'd1023 : 10'd0;
	endfunction

	task automatic push_command(input logic [2:0] cmd, input logic [2:0] sel,
			input logic [7:0] data, input logic [9:0] clocks);
		int gap;
		int r;
		gap = 0;
		if (idling_enabled) begin
			r = $urandom_range(0, 99);
			if (r >= 90)
				gap = $urandom_range(8, 40);
			else if (r >= 60)
				gap = $urandom_range(1, 3);
		end
		@(negedge clk);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		command = cmd;
		reg_select = sel;
		write_data = data;
		clock_count = clocks;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		expected_samples.push_back(step_channel(cmd, sel, data, clocks));
	endtask

	// reset state, unknown commands and writes to unknown registers
	task automatic test_idle_defaults();
		push_command(CMD_TIMER, REG_SWEEP, 8'h00, 10'd0);
		push_command(CMD_LENGTH, REG_SWEEP, 8'h00, 10'd0);
		push_command(CMD_ENV, REG_SWEEP, 8'h00, 10'd0);
		push_command(CMD_SWEEP, REG_SWEEP, 8'h00, 10'd1023);
		for (int c = CMD_SWEEP + 1; c < 8; c++)
			push_command(3'(c), REG_CTRL, 8'hFF, 10'd1023);
		for (int s = NUM_REGS; s < 8; s++)
			push_command(CMD_WRITE, 3'(s), 8'hFF, 10'd0);
	endtask

	// all-ones registers, highest frequency, length of one
	task automatic test_trigger_extremes();
		push_command(CMD_WRITE, REG_DUTY, 8'hFF, 10'd0);
		push_command(CMD_WRITE, REG_ENV, 8'hFF, 10'd0);
		push_command(CMD_WRITE, REG_FLO, 8'hFF, 10'd0);
		push_command(CMD_WRITE, REG_CTRL, TRIGGER | 8'h47, 10'd0);
		push_command(CMD_TIMER, REG_SWEEP, 8'h00, 10'd1023);
		push_command(CMD_LENGTH, REG_SWEEP, 8'h00, 10'd0);
	endtask

	// upward sweep overflow, then a downward sweep with the largest shift
	task automatic test_sweep_cases();
		push_command(CMD_WRITE, REG_SWEEP, 8'h11, 10'd0);
		push_command(CMD_WRITE, REG_CTRL, TRIGGER | 8'h07, 10'd0);
		push_command(CMD_SWEEP, REG_SWEEP, 8'h00, 10'd0);
		push_command(CMD_WRITE, REG_SWEEP, 8'h1F, 10'd0);
		push_command(CMD_SWEEP, REG_SWEEP, 8'h00, 10'd0);
	endtask

	// DAC off on trigger, volume already at the floor
	task automatic test_envelope_floor();
		push_command(CMD_WRITE, REG_ENV, 8'h01, 10'd0);
		push_command(CMD_WRITE, REG_CTRL, TRIGGER, 10'd0);
		push_command(CMD_ENV, REG_SWEEP, 8'h00, 10'd0);
		push_command(CMD_ENV, REG_SWEEP, 8'h00, 10'd0);
	endtask

	// mostly set-up-and-trigger runs followed by clock events, some noise
	task automatic test_random_sequences(input int n_items);
		int done;
		int r;
		logic [2:0] cmd;
		logic [7:0] ctrl;
		done = 0;
		while (done < n_items) begin
			idling_enabled = ($urandom_range(0, 4) != 0);
			if ($urandom_range(0, 9) < 8) begin
				for (int s = REG_SWEEP; s <= REG_FLO; s++) begin
					if ($urandom_range(0, 9) < 7) begin
						push_command(CMD_WRITE, 3'(s), 8'($urandom_range(0, 255)),
							pick_clocks());
						done++;
					end
				end
				ctrl = 8'($urandom_range(0, 255));
				if ($urandom_range(0, 9) != 0)
					ctrl |= TRIGGER;
				push_command(CMD_WRITE, REG_CTRL, ctrl, pick_clocks());
				done++;
				repeat ($urandom_range(4, 40)) begin
					r = $urandom_range(0, 99);
					cmd = (r < 40) ? CMD_TIMER : (r < 65) ? CMD_SWEEP :
						(r < 80) ? CMD_ENV : (r < 95) ? CMD_LENGTH : CMD_WRITE;
					push_command(cmd, 3'($urandom_range(0, NUM_REGS - 1)),
						8'($urandom_range(0, 255)), pick_clocks());
					done++;
				end
			end else begin
				repeat ($urandom_range(1, 6))
					push_command(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
						8'($urandom_range(0, 255)), pick_clocks());
			end
		end
		idling_enabled = 1'b1;
	endtask

	// output side back-pressure
	initial begin
		int r;
		int stall_left;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (!idling_enabled) begin
				out_ready = 1'b1;
				stall_left = 0;
			end else if (stall_left > 0) begin
				out_ready = 1'b0;
				stall_left--;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 65) begin
					out_ready = 1'b1;
				end else begin
					out_ready = 1'b0;
					stall_left = (r < 92) ? $urandom_range(0, 2) : $urandom_range(8, 40);
				end
			end
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_samples.size() == 0) begin
				report_fail("result with nothing expected");
			end else begin
				want = expected_samples.pop_front();
				if (sample !== want.sample)
					report_fail($sformatf("sample %0h, expected %0h", sample, want.sample));
				if (channel_on !== want.channel_on)
					report_fail($sformatf("channel_on %b, expected %b", channel_on,
						want.channel_on));
				if (dac_on !== want.dac_on)
					report_fail($sformatf("dac_on %b, expected %b", dac_on, want.dac_on));
			end
		end
	end

	// nothing accepted on either side for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_idle_defaults();
		test_trigger_extremes();
		test_sweep_cases();
		test_envelope_floor();
		test_random_sequences(1200);
		@(negedge clk);
		in_valid = 1'b0;
		while (expected_samples.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && expected_samples.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

`default_nettype wire

// ===== files.f =====
sv/sqch_pkg.sv
sv/sqch_in_reg.sv
sv/sqch_core.sv
sv/square_channel_with_sweep.sv
tb/sv/tb_top.sv
